// ----- design/ildf_pkg.sv -----
package ildf_pkg;

  // Block configuration.
  localparam int AVG_TAPS     = 5;
  localparam int SAMPLE_BITS  = 12;
  localparam int TABLE_POINTS = 11;

  // Breakpoint table.
  localparam int LUT_SIZE = 11;
  localparam int LUT_USED = (TABLE_POINTS < LUT_SIZE) ?
                            ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS) : LUT_SIZE;
  localparam int SEG_W    = (LUT_USED > 2) ? $clog2(LUT_USED - 1) : 1;

  // Datapath widths.
  localparam int CODE_W      = 12;
  localparam int DIST_W      = 11;
  localparam int DX_W        = 9;   // the widest segment spans 497 codes
  localparam int DELTA_W     = 9;
  localparam int NUM_W       = 18;  // dx * delta + span / 2 stays below 2**18
  localparam int DOWN_SHIFT  = (SAMPLE_BITS > CODE_W) ? SAMPLE_BITS - CODE_W : 0;
  localparam int UP_SHIFT    = (SAMPLE_BITS < CODE_W) ? CODE_W - SAMPLE_BITS : 0;

  // Division by a segment span is a multiply by a rounded-up reciprocal.
  // With a numerator below 2**18 and spans below 2**9 the quotient is exact.
  localparam int RECIP_S   = 27;
  localparam int RECIP_W   = 21;
  localparam int RECIP_ONE = 1 << RECIP_S;

  // Window and averaging.
  localparam int POS_W       = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int SUM_W       = DIST_W + $clog2(AVG_TAPS);
  localparam int AVG_S       = SUM_W + $clog2(AVG_TAPS);
  localparam int AVG_RECIP_W = AVG_S + 1;
  localparam int AVG_ONE     = 1 << AVG_S;
  localparam int AVG_RECIP   = (AVG_ONE + AVG_TAPS - 1) / AVG_TAPS;

  // Ports.
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_DATA_W-1:0] NEAR_RESET = 11'd288;
  localparam logic [CFG_DATA_W-1:0] FAR_RESET  = 11'd352;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NEAR = 1'b0,
    CFG_FAR  = 1'b1
  } cfg_reg_e;

  localparam logic [CODE_W-1:0] LUT_CODE [LUT_SIZE] = '{
    12'd434, 12'd559, 12'd683, 12'd869, 12'd1117, 12'd1365,
    12'd1676, 12'd2048, 12'd2482, 12'd2979, 12'd3413
  };

  localparam logic [DIST_W-1:0] LUT_DIST [LUT_SIZE] = '{
    11'd1280, 11'd800, 11'd560, 11'd400, 11'd288, 11'd224,
    11'd176, 11'd136, 11'd112, 11'd88, 11'd64
  };

  // Per segment: distance drop across the segment, half span, reciprocal.
  localparam logic [DELTA_W-1:0] SEG_DELTA [LUT_SIZE-1] = '{
    9'd480, 9'd240, 9'd160, 9'd112, 9'd64, 9'd48, 9'd40, 9'd24, 9'd24, 9'd24
  };

  localparam logic [DX_W-1:0] SEG_HALF [LUT_SIZE-1] = '{
    9'd62, 9'd62, 9'd93, 9'd124, 9'd124, 9'd155, 9'd186, 9'd217, 9'd248, 9'd217
  };

  localparam logic [RECIP_W-1:0] SEG_RECIP [LUT_SIZE-1] = '{
    RECIP_W'((RECIP_ONE + 124) / 125),
    RECIP_W'((RECIP_ONE + 123) / 124),
    RECIP_W'((RECIP_ONE + 185) / 186),
    RECIP_W'((RECIP_ONE + 247) / 248),
    RECIP_W'((RECIP_ONE + 247) / 248),
    RECIP_W'((RECIP_ONE + 310) / 311),
    RECIP_W'((RECIP_ONE + 371) / 372),
    RECIP_W'((RECIP_ONE + 433) / 434),
    RECIP_W'((RECIP_ONE + 496) / 497),
    RECIP_W'((RECIP_ONE + 433) / 434)
  };

endpackage

// ----- design/ildf_interp.sv -----
module ildf_interp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ildf_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ildf_pkg::DIST_W-1:0]      dist_o
);
  import ildf_pkg::*;

  logic                   smp_vld_q, seg_vld_q, dist_vld_q;
  logic                   smp_rdy, seg_rdy, dist_rdy;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [CODE_W-1:0]      code;
  logic [CODE_W-1:0]      dx_full;
  logic [DX_W-1:0]        dx;
  logic [SEG_W-1:0]       seg_d, seg_q;
  logic [NUM_W-1:0]       num_d, num_q;
  logic [DIST_W-1:0]      base_d, base_q;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [DIST_W-1:0]      dist_d, dist_q;

  // Each stage takes a new item when it is empty or its item moves on.
  assign dist_rdy   = !dist_vld_q || out_ready_i;
  assign seg_rdy    = !seg_vld_q || dist_rdy;
  assign smp_rdy    = !smp_vld_q || seg_rdy;
  assign in_ready_o = smp_rdy;

  assign code = CODE_W'((32'(sample_q) >> DOWN_SHIFT) << UP_SHIFT);

  // Segment search: the last breakpoint at or below the code.
  always_comb begin
    seg_d = '0;
    for (int i = 1; i < LUT_USED - 1; i++) begin
      if (code >= LUT_CODE[i]) begin
        seg_d = SEG_W'(i);
      end
    end
  end

  assign dx_full = code - LUT_CODE[seg_d];
  assign dx      = dx_full[DX_W-1:0];

  always_comb begin
    if (code <= LUT_CODE[0]) begin
      num_d  = '0;
      base_d = LUT_DIST[0];
    end else if (code >= LUT_CODE[LUT_USED-1]) begin
      num_d  = '0;
      base_d = LUT_DIST[LUT_USED-1];
    end else begin
      num_d  = NUM_W'(dx) * NUM_W'(SEG_DELTA[seg_d]) + NUM_W'(SEG_HALF[seg_d]);
      base_d = LUT_DIST[seg_d];
    end
  end

  // The table falls monotonically, so the rounded share is always a drop.
  assign prod   = (NUM_W+RECIP_W)'(num_q) * (NUM_W+RECIP_W)'(SEG_RECIP[seg_q]);
  assign dist_d = base_q - prod[RECIP_S +: DIST_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q  <= 1'b0;
      seg_vld_q  <= 1'b0;
      dist_vld_q <= 1'b0;
    end else begin
      if (smp_rdy) begin
        smp_vld_q <= in_valid_i;
      end
      if (seg_rdy) begin
        seg_vld_q <= smp_vld_q;
      end
      if (dist_rdy) begin
        dist_vld_q <= seg_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && smp_rdy) begin
      sample_q <= sample_i;
    end
    if (smp_vld_q && seg_rdy) begin
      seg_q  <= seg_d;
      num_q  <= num_d;
      base_q <= base_d;
    end
    if (seg_vld_q && dist_rdy) begin
      dist_q <= dist_d;
    end
  end

  assign out_valid_o = dist_vld_q;
  assign dist_o      = dist_q;

  a_dist_in_table_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_vld_q |-> (dist_q <= LUT_DIST[0]) && (dist_q >= LUT_DIST[LUT_USED-1]))
    else $error("interpolated distance outside the table range");

  a_stage_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_vld_q && !out_ready_i) |=> dist_vld_q && $stable(dist_q))
    else $error("distance stage lost its item while stalled");

endmodule

// ----- design/ildf_window.sv -----
module ildf_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ildf_pkg::DIST_W-1:0] dist_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ildf_pkg::SUM_W-1:0]  sum_o
);
  import ildf_pkg::*;

  logic [DIST_W-1:0] window_q [AVG_TAPS];
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  check_sum;
  logic              vld_q;
  logic              load;

  assign in_ready_o = !vld_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Running sum: drop the oldest entry, add the new distance.
  assign sum_d = sum_q - SUM_W'(window_q[pos_q]) + SUM_W'(dist_i);
  assign pos_d = (pos_q == POS_W'(AVG_TAPS - 1)) ? '0 : pos_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_TAPS; i++) begin
        window_q[i] <= '0;
      end
      pos_q <= '0;
      sum_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        window_q[pos_q] <= dist_i;
        pos_q           <= pos_d;
        sum_q           <= sum_d;
      end
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
    end
  end

  assign out_valid_o = vld_q;
  assign sum_o       = sum_q;

  always_comb begin
    check_sum = '0;
    for (int i = 0; i < AVG_TAPS; i++) begin
      check_sum = check_sum + SUM_W'(window_q[i]);
    end
  end

  a_sum_matches_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q == check_sum)
    else $error("running sum differs from the window contents");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(AVG_TAPS - 1))
    else $error("write position beyond the window");

endmodule

// ----- design/ildf_detect.sv -----
module ildf_detect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ildf_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [ildf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ildf_pkg::SUM_W-1:0]      sum_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ildf_pkg::DIST_W-1:0]     avg_o,
  output logic                            detected_o
);
  import ildf_pkg::*;

  logic [CFG_DATA_W-1:0]        near_q, far_q;
  logic [SUM_W+AVG_RECIP_W-1:0] prod;
  logic [DIST_W-1:0]            avg_d, avg_q;
  logic                         presence_d, presence_q;
  logic                         vld_q;
  logic                         load;

  assign in_ready_o = !vld_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Division by the tap count as a multiply by its rounded-up reciprocal.
  assign prod  = (SUM_W+AVG_RECIP_W)'(sum_i) * (SUM_W+AVG_RECIP_W)'(AVG_RECIP);
  assign avg_d = prod[AVG_S +: DIST_W];

  // Hysteresis: the clear test is applied last, so it wins.
  always_comb begin
    presence_d = presence_q;
    if (avg_d < near_q) begin
      presence_d = 1'b1;
    end
    if (avg_d > far_q) begin
      presence_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q     <= NEAR_RESET;
      far_q      <= FAR_RESET;
      presence_q <= 1'b0;
      vld_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          CFG_NEAR: near_q <= cfg_wdata_i;
          CFG_FAR:  far_q  <= cfg_wdata_i;
        endcase
      end
      if (load) begin
        presence_q <= presence_d;
      end
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      avg_q <= avg_d;
    end
  end

  assign out_valid_o = vld_q;
  assign avg_o       = avg_q;
  assign detected_o  = presence_q;

  a_far_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (avg_d > far_q)) |=> !presence_q)
    else $error("presence not cleared above the far threshold");

  a_near_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (avg_d < near_q) && (avg_d <= far_q)) |=> presence_q)
    else $error("presence not set below the near threshold");

endmodule

// ----- design/ir_distance_lut_filter_core.sv -----
// Channel   Direction  Handshake                        Payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o  one converter sample per item
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i  averaged distance and presence flag
// cfg       in         cfg_we_i, no back-pressure       threshold writes by register index
//
// An item passes five registers on its way out after it is accepted: input register, segment
// and numerator register, distance register, window sum register, result register.
// One item is accepted every cycle while the output side takes results.
// Empty stages close up under a stall, so s_axis_tready_o falls only once all five
// stages hold items and m_axis_tready_i is low.
// Reset clears the window, its sum and position, and the presence flag, and loads
// the near and far thresholds with 18.0 cm and 22.0 cm.
module ir_distance_lut_filter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: index 0 is near_threshold, index 1 is far_threshold.
  input  logic                            cfg_we_i,
  input  logic [ildf_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [ildf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [ildf_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // [11:0] adc_sample
  // Output stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [ildf_pkg::M_TDATA_W-1:0]  m_axis_tdata_o   // [10:0] avg_distance, [11] detected
);
  import ildf_pkg::*;

  // Between the stages, each item carries its own valid and ready.
  logic              dist_valid, dist_ready;
  logic [DIST_W-1:0] interp_dist;
  logic              sum_valid, sum_ready;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] avg_distance;
  logic              detected;

  // Interpolation: input register, segment lookup with the numerator product,
  // then the reciprocal multiply that divides by the segment span.
  ildf_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .sample_i    (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .out_valid_o (dist_valid),
    .out_ready_i (dist_ready),
    .dist_o      (interp_dist)
  );

  // Ring window with a running sum; the state advances once per item.
  ildf_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dist_valid),
    .in_ready_o  (dist_ready),
    .dist_i      (interp_dist),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .sum_o       (sum)
  );

  // Average, hysteresis flag, thresholds and the result register.
  ildf_detect u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .sum_i       (sum),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .avg_o       (avg_distance),
    .detected_o  (detected)
  );

  assign m_axis_tdata_o = M_TDATA_W'({detected, avg_distance});

endmodule
